// ----- src/cdq_pkg.sv -----
// Package for the circular deque: sizes, the operation codes and the
// transaction types of the request and response channels.
// Has no dependencies; circular_deque in src refers to it by scoped names.
package cdq_pkg;

    localparam int DEPTH      = 1024;
    localparam int DATA_WIDTH = 32;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int VALUE_W    = 32;
    localparam int OCC_W      = 11;

    typedef logic [ADDR_W-1:0]     addr_t;
    typedef logic [CNT_W-1:0]      cnt_t;
    typedef logic [DATA_WIDTH-1:0] data_t;
    typedef logic [VALUE_W-1:0]    value_t;
    typedef logic [OCC_W-1:0]      occ_t;

    typedef enum logic [1:0] {
        MODE_PUSH_FRONT = 2'd0,
        MODE_PUSH_BACK  = 2'd1,
        MODE_POP_FRONT  = 2'd2,
        MODE_POP_BACK   = 2'd3
    } mode_t;

    typedef struct packed {
        mode_t                     mode;
        logic signed [VALUE_W-1:0] push_value;
    } req_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] pop_value;
        logic                      empty_error;
        logic                      full_error;
        occ_t                      occupancy;
    } rsp_t;

endpackage

// ----- src/cdq_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; used by the circular deque for its entry store.
module cdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- src/circular_deque.sv -----
// Top level of the circular deque: pointer and count control around one RAM.
// Depends on cdq_pkg and cdq_ram.
//
// Use: each request transaction carries a mode (push front, push back, pop
// front, pop back) and a value used only by pushes. Every request produces
// exactly one response transaction carrying the popped value, the empty and
// full error flags and the number of stored entries after the operation.
// A pop on an empty deque returns zero with empty_error set; a push on a full
// deque is dropped with full_error set.
// The RAM read and the middle stage load at the accepting edge, and the
// response register loads from them when the middle stage moves on.
// Throughput: one request per cycle while req_stall is low, set by the
// single RAM access each operation needs; pointers and count are updated
// at the accepting edge, so a following operation always sees the earlier
// one's effect in the RAM.
// When the response side stalls, the middle stage and the response register
// fill, and req_stall rises until the response is taken.
// Reset empties the deque at once (pointers and count to zero); the RAM
// contents are not cleared and no clearing pass is needed.
module circular_deque (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  cdq_pkg::req_t  req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output cdq_pkg::rsp_t  rsp
);

    typedef struct packed {
        logic              pop_ok;
        logic              empty_error;
        logic              full_error;
        cdq_pkg::occ_t     occupancy;
    } meta_t;

    cdq_pkg::addr_t head_reg, head_next;
    cdq_pkg::addr_t tail_reg, tail_next;
    cdq_pkg::cnt_t  count_reg, count_next;

    logic           s1_valid_reg;
    meta_t          s1_meta_reg, s1_meta_next;
    logic           rsp_valid_reg;
    cdq_pkg::rsp_t  rsp_reg;

    logic           s1_adv;
    logic           req_acc;
    logic           is_full;
    logic           is_empty;
    logic           wr_en;
    logic           rd_en;
    cdq_pkg::addr_t wr_addr;
    cdq_pkg::addr_t rd_addr;
    cdq_pkg::data_t rd_data;

    function automatic cdq_pkg::addr_t wrap_inc(input cdq_pkg::addr_t p);
        return (p == cdq_pkg::addr_t'(cdq_pkg::DEPTH - 1)) ? '0 : p + cdq_pkg::addr_t'(1);
    endfunction

    function automatic cdq_pkg::addr_t wrap_dec(input cdq_pkg::addr_t p);
        return (p == '0) ? cdq_pkg::addr_t'(cdq_pkg::DEPTH - 1) : p - cdq_pkg::addr_t'(1);
    endfunction

    // The middle stage moves on whenever the response register is free or
    // being emptied in this cycle.
    assign s1_adv    = s1_valid_reg && (!rsp_valid_reg || !rsp_stall);
    assign req_stall = s1_valid_reg && !s1_adv;
    assign req_acc   = req_valid && !req_stall;
    assign is_full   = (count_reg == cdq_pkg::cnt_t'(cdq_pkg::DEPTH));
    assign is_empty  = (count_reg == '0);

    always_comb
    begin
        head_next    = head_reg;
        tail_next    = tail_reg;
        count_next   = count_reg;
        wr_en        = 1'b0;
        rd_en        = 1'b0;
        wr_addr      = tail_reg;
        rd_addr      = head_reg;
        s1_meta_next = '0;
        unique case (req.mode)
            cdq_pkg::MODE_PUSH_FRONT:
            begin
                if (is_full)
                begin
                    s1_meta_next.full_error = 1'b1;
                end
                else
                begin
                    head_next  = wrap_dec(head_reg);
                    wr_addr    = wrap_dec(head_reg);
                    wr_en      = req_acc;
                    count_next = count_reg + cdq_pkg::cnt_t'(1);
                end
            end
            cdq_pkg::MODE_PUSH_BACK:
            begin
                if (is_full)
                begin
                    s1_meta_next.full_error = 1'b1;
                end
                else
                begin
                    tail_next  = wrap_inc(tail_reg);
                    wr_addr    = tail_reg;
                    wr_en      = req_acc;
                    count_next = count_reg + cdq_pkg::cnt_t'(1);
                end
            end
            cdq_pkg::MODE_POP_FRONT:
            begin
                if (is_empty)
                begin
                    s1_meta_next.empty_error = 1'b1;
                end
                else
                begin
                    head_next           = wrap_inc(head_reg);
                    rd_addr             = head_reg;
                    rd_en               = req_acc;
                    s1_meta_next.pop_ok = 1'b1;
                    count_next          = count_reg - cdq_pkg::cnt_t'(1);
                end
            end
            cdq_pkg::MODE_POP_BACK:
            begin
                if (is_empty)
                begin
                    s1_meta_next.empty_error = 1'b1;
                end
                else
                begin
                    tail_next           = wrap_dec(tail_reg);
                    rd_addr             = wrap_dec(tail_reg);
                    rd_en               = req_acc;
                    s1_meta_next.pop_ok = 1'b1;
                    count_next          = count_reg - cdq_pkg::cnt_t'(1);
                end
            end
            default:
            begin
                s1_meta_next = '0;
            end
        endcase
        s1_meta_next.occupancy = cdq_pkg::occ_t'(count_next);
    end

    cdq_ram #(
        .WIDTH (cdq_pkg::DATA_WIDTH),
        .DEPTH (cdq_pkg::DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (cdq_pkg::data_t'(req.push_value)),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (req_acc)
            begin
                head_reg  <= head_next;
                tail_reg  <= tail_next;
                count_reg <= count_next;
            end
            if (req_acc)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // The RAM read data holds while the middle stage waits, since no new
    // read is issued until a request is accepted again.
    always_ff @(posedge clk)
    begin
        if (req_acc)
        begin
            s1_meta_reg <= s1_meta_next;
        end
        if (s1_adv)
        begin
            rsp_reg.pop_value   <= s1_meta_reg.pop_ok ? cdq_pkg::value_t'(rd_data) : '0;
            rsp_reg.empty_error <= s1_meta_reg.empty_error;
            rsp_reg.full_error  <= s1_meta_reg.full_error;
            rsp_reg.occupancy   <= s1_meta_reg.occupancy;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= cdq_pkg::cnt_t'(cdq_pkg::DEPTH))
        else $error("entry count exceeds the deque depth");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        !req_acc |=> count_reg == $past(count_reg))
        else $error("entry count changed without an accepted transaction");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> (s1_valid_reg && rsp_valid_reg && rsp_stall))
        else $error("request stalled while the pipeline could move");

    a_stage_fill: assert property (@(posedge clk) disable iff (!rst_n)
        req_acc |=> s1_valid_reg)
        else $error("accepted transaction lost before the read stage");

    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> !(rsp.empty_error && rsp.full_error))
        else $error("empty and full errors raised together");

    a_error_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp.empty_error || rsp.full_error)) |-> (rsp.pop_value == '0))
        else $error("error response carries a non-zero value");
`endif

endmodule

// ----- test/testbench.sv -----
// Self-checking testbench for circular_deque: a queue-fed driver, a monitor that
// predicts each response from its own deque model and compares it field by field.
// Depends on cdq_pkg and the RTL in src.
`timescale 1ns / 100ps

module testbench;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    cdq_pkg::req_t req = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    cdq_pkg::rsp_t rsp;

    circular_deque dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #6 clk = ~clk;

    // Request transactions waiting to be driven, and responses still owed by the block.
    cdq_pkg::req_t pending_req_q[$];
    cdq_pkg::rsp_t expected_rsp_q[$];
    cdq_pkg::rsp_t expected_rsp;
    int   idle_pct = 0;
    int   stall_pct = 0;
    int   error_count = 0;
    int   planned_count = 0;

    // Our own view of the deque contents.
    cdq_pkg::data_t deq_store [cdq_pkg::DEPTH];
    cdq_pkg::addr_t deq_head = '0;
    cdq_pkg::addr_t deq_tail = '0;
    cdq_pkg::cnt_t  deq_level = '0;

    function automatic cdq_pkg::rsp_t predict_deque_op(cdq_pkg::req_t r);
        cdq_pkg::rsp_t res;
        res = '0;
        if (r.mode == cdq_pkg::MODE_PUSH_FRONT || r.mode == cdq_pkg::MODE_PUSH_BACK)
        begin
            if (deq_level >= cdq_pkg::cnt_t'(cdq_pkg::DEPTH))
                res.full_error = 1'b1;
            else
            begin
                if (r.mode == cdq_pkg::MODE_PUSH_FRONT)
                begin
                    deq_head = (deq_head == '0) ? cdq_pkg::addr_t'(cdq_pkg::DEPTH - 1)
                                                : deq_head - cdq_pkg::addr_t'(1);
                    deq_store[deq_head] = cdq_pkg::data_t'(r.push_value);
                end
                else
                begin
                    deq_store[deq_tail] = cdq_pkg::data_t'(r.push_value);
                    deq_tail = (deq_tail == cdq_pkg::addr_t'(cdq_pkg::DEPTH - 1))
                               ? '0 : deq_tail + cdq_pkg::addr_t'(1);
                end
                deq_level++;
            end
        end
        else if (deq_level == '0)
            res.empty_error = 1'b1;
        else
        begin
            if (r.mode == cdq_pkg::MODE_POP_FRONT)
            begin
                res.pop_value = cdq_pkg::value_t'(deq_store[deq_head]);
                deq_head = (deq_head == cdq_pkg::addr_t'(cdq_pkg::DEPTH - 1))
                           ? '0 : deq_head + cdq_pkg::addr_t'(1);
            end
            else
            begin
                deq_tail = (deq_tail == '0) ? cdq_pkg::addr_t'(cdq_pkg::DEPTH - 1)
                                            : deq_tail - cdq_pkg::addr_t'(1);
                res.pop_value = cdq_pkg::value_t'(deq_store[deq_tail]);
            end
            deq_level--;
        end
        res.occupancy = cdq_pkg::occ_t'(deq_level);
        return res;
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            error_count++;
        end
    endtask

    // The planned count lets the final stimulus drain the deque to empty.
    task automatic queue_op(cdq_pkg::mode_t m, cdq_pkg::value_t v);
        cdq_pkg::req_t item;
        item.mode = m;
        item.push_value = v;
        pending_req_q.push_back(item);
        if (m == cdq_pkg::MODE_PUSH_FRONT || m == cdq_pkg::MODE_PUSH_BACK)
        begin
            if (planned_count < cdq_pkg::DEPTH)
                planned_count++;
        end
        else if (planned_count > 0)
            planned_count--;
    endtask

    function automatic cdq_pkg::value_t rand_value();
        case ($urandom_range(0, 7))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic cdq_pkg::mode_t pick_mode(int push_pct);
        if ($urandom_range(0, 99) < push_pct)
            return $urandom_range(0, 1) ? cdq_pkg::MODE_PUSH_BACK : cdq_pkg::MODE_PUSH_FRONT;
        return $urandom_range(0, 1) ? cdq_pkg::MODE_POP_BACK : cdq_pkg::MODE_POP_FRONT;
    endfunction

    task automatic wait_drained();
        while (pending_req_q.size() != 0 || req_valid || expected_rsp_q.size() != 0)
            @(posedge clk);
    endtask

    // Driver: holds a stalled transaction, otherwise offers the next one or idles.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req <= '0;
        end
        else if (!req_valid || !req_stall)
        begin
            if (pending_req_q.size() > 0 && $urandom_range(0, 99) >= idle_pct)
            begin
                req_valid <= 1'b1;
                req <= pending_req_q.pop_front();
            end
            else
                req_valid <= 1'b0;
        end
    end

    // Monitor: records accepted requests before checking responses, so even a
    // response in the same cycle finds its expectation.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_stall <= 1'b0;
        else
        begin
            if (req_valid && !req_stall)
                expected_rsp_q.push_back(predict_deque_op(req));
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_rsp_q.size() == 0)
                begin
                    $error("response transaction with no request outstanding");
                    error_count++;
                end
                else
                begin
                    expected_rsp = expected_rsp_q.pop_front();
                    check_field("pop_value", expected_rsp.pop_value, rsp.pop_value);
                    check_field("empty_error", 32'(expected_rsp.empty_error),
                                32'(rsp.empty_error));
                    check_field("full_error", 32'(expected_rsp.full_error),
                                32'(rsp.full_error));
                    check_field("occupancy", 32'(expected_rsp.occupancy),
                                32'(rsp.occupancy));
                end
            end
            rsp_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    initial
    begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

    initial
    begin
        int idle_set [4];
        int stall_set [4];
        int bias;
        idle_set  = '{0, 58, 0, 32};
        stall_set = '{0, 0, 58, 32};

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: pops on an empty deque, extreme values pushed at both ends
        // (the first front push wraps the head), then popped back in known order and once more past empty.
        queue_op(cdq_pkg::MODE_POP_FRONT, 32'h1234_5678);
        queue_op(cdq_pkg::MODE_POP_BACK, 32'hFFFF_FFFF);
        queue_op(cdq_pkg::MODE_PUSH_FRONT, 32'h7FFF_FFFF);
        queue_op(cdq_pkg::MODE_PUSH_BACK, 32'h8000_0000);
        queue_op(cdq_pkg::MODE_PUSH_FRONT, 32'hFFFF_FFFF);
        queue_op(cdq_pkg::MODE_PUSH_BACK, 32'h0000_0000);
        queue_op(cdq_pkg::MODE_PUSH_FRONT, 32'hAAAA_AAAA);
        queue_op(cdq_pkg::MODE_PUSH_BACK, 32'h5555_5555);
        queue_op(cdq_pkg::MODE_POP_BACK, 32'h0);
        queue_op(cdq_pkg::MODE_POP_FRONT, 32'h0);
        queue_op(cdq_pkg::MODE_POP_FRONT, 32'h0);
        queue_op(cdq_pkg::MODE_POP_BACK, 32'h0);
        queue_op(cdq_pkg::MODE_POP_BACK, 32'h0);
        queue_op(cdq_pkg::MODE_POP_FRONT, 32'h0);
        queue_op(cdq_pkg::MODE_POP_BACK, 32'h0);

        // Random mixes, with the sender holding off until the block is empty
        // of work before each change of flow-control pattern.
        for (int p = 0; p < 4; p++)
        begin
            wait_drained();
            idle_pct = idle_set[p];
            stall_pct = stall_set[p];
            repeat (7)
            begin
                case ($urandom_range(0, 2))
                    0: bias = 80;
                    1: bias = 50;
                    default: bias = 20;
                endcase
                repeat (20)
                    queue_op(pick_mode(bias), rand_value());
            end
        end

        // Drain whatever is left, then pop the empty deque at both ends.
        while (planned_count > 0)
            queue_op(pick_mode(0), rand_value());
        queue_op(cdq_pkg::MODE_POP_FRONT, rand_value());
        queue_op(cdq_pkg::MODE_POP_BACK, rand_value());

        wait_drained();
        repeat (10) @(posedge clk);
        if (error_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ----- sim.f -----
src/cdq_pkg.sv
src/cdq_ram.sv
src/circular_deque.sv
test/testbench.sv
